[rtl/bpfa_pkg.sv]
// Shared types, constants and helper functions of the bitmap page frame allocator.
`timescale 1ns / 1ps

package bpfa_pkg;

    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned BLOCK_BYTES = 4096;
    localparam int unsigned BLOCK_SHIFT = $clog2(BLOCK_BYTES);
    // Block numbers and run ends, one bit wider than an address shifted down.
    localparam int unsigned BLK_W       = ADDR_W - BLOCK_SHIFT + 1;
    localparam int unsigned WORD_BITS   = 32;
    localparam int unsigned BIT_W       = $clog2(WORD_BITS);
    localparam logic [WORD_BITS-1:0] FULL_WORD = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        ACT_ALLOC         = 3'd0,
        ACT_FREE          = 3'd1,
        ACT_REGION_USED   = 3'd2,
        ACT_REGION_UNUSED = 3'd3,
        ACT_TEST          = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OOM   = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PREP,
        S_SPAN,
        S_FIX0,
        S_SCAN,
        S_TEST_RD,
        S_TEST_DATA,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]        action;
        logic [ADDR_W-1:0] byte_address;
        logic [31:0]       size_bytes;
        logic [14:0]       block_index;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] alloc_address;
        logic              block_used;
        logic [1:0]        status;
    } rsp_t;

    // Position of the lowest clear bit of a word that is known not to be full.
    function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

    // Ones from bit lo up to bit hi inclusive.
    function automatic logic [WORD_BITS-1:0] span_mask(input logic [BIT_W-1:0] lo,
                                                       input logic [BIT_W-1:0] hi);
        return (FULL_WORD << lo) & (FULL_WORD >> (BIT_W'(WORD_BITS - 1) - hi));
    endfunction

endpackage

[rtl/bpfa_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module bpfa_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/bpfa_ctrl.sv]
// Sequencer that runs each item as read or read-modify-write passes on the bitmap.
`timescale 1ns / 1ps

module bpfa_ctrl #(
    parameter int unsigned NUM_BLOCKS = 32768
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_ready,
    input  bpfa_pkg::req_t          req,
    output logic                    res_valid,
    input  logic                    res_ready,
    output bpfa_pkg::rsp_t          res,
    output logic                    mem_wr_en,
    output logic [((NUM_BLOCKS + 31) / 32 > 1 ? $clog2((NUM_BLOCKS + 31) / 32) : 1)-1:0]
                                    mem_wr_addr,
    output logic [31:0]             mem_wr_data,
    output logic                    mem_rd_en,
    output logic [((NUM_BLOCKS + 31) / 32 > 1 ? $clog2((NUM_BLOCKS + 31) / 32) : 1)-1:0]
                                    mem_rd_addr,
    input  logic [31:0]             mem_rd_data
);

    localparam int unsigned WORD_COUNT = (NUM_BLOCKS + 31) / 32;
    localparam int unsigned WAW        = WORD_COUNT > 1 ? $clog2(WORD_COUNT) : 1;
    localparam int unsigned BLK_W      = bpfa_pkg::BLK_W;
    localparam int unsigned BIT_W      = bpfa_pkg::BIT_W;
    localparam int unsigned SHIFT      = bpfa_pkg::BLOCK_SHIFT;
    localparam int unsigned ADDR_W     = bpfa_pkg::ADDR_W;
    localparam logic [WAW-1:0]   LAST_WORD = WAW'(WORD_COUNT - 1);
    localparam logic [BLK_W-1:0] NUM_B     = BLK_W'(NUM_BLOCKS);

    bpfa_pkg::state_t  state_reg, state_next;
    bpfa_pkg::req_t    item_reg, item_next;
    bpfa_pkg::status_t status_reg, status_next;
    logic [WAW-1:0]    cur_reg, cur_next;
    logic [WAW-1:0]    pw_reg, pw_next;
    logic              last_reg, last_next;
    logic              pend_reg, pend_next;
    logic [BLK_W-1:0]  lo_reg, lo_next;
    logic [BLK_W-1:0]  hi_reg, hi_next;
    logic              set_reg, set_next;
    logic              fix0_reg, fix0_next;
    logic              used_reg, used_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;

    // Block arithmetic for the item held in item_reg.
    logic [BLK_W-1:0] start_blk;
    logic [BLK_W-1:0] cnt_up;
    logic [BLK_W-1:0] cnt_dn;
    logic [BLK_W-1:0] cnt;
    logic [BLK_W-1:0] end_raw;
    logic             over;
    logic [BLK_W-1:0] idx_ext;

    // Walk bounds.
    logic [BLK_W-1:0] last_blk;
    logic [WAW-1:0]   fw;
    logic [WAW-1:0]   lw;
    logic [BIT_W-1:0] lob;
    logic [BIT_W-1:0] hib;
    logic [31:0]      mask;

    // Scan result.
    logic             hit;
    logic [BIT_W-1:0] zbit;
    logic [WAW+BIT_W-1:0] found;

    always_comb
    begin
        start_blk = {1'b0, item_reg.byte_address[ADDR_W-1:SHIFT]};
        cnt_dn    = {1'b0, item_reg.size_bytes[31:SHIFT]};
        cnt_up    = cnt_dn + BLK_W'(|item_reg.size_bytes[SHIFT-1:0]);
        cnt       = (item_reg.action == bpfa_pkg::ACT_REGION_USED) ? cnt_up : cnt_dn;
        end_raw   = start_blk + cnt;
        over      = end_raw > NUM_B;
        idx_ext   = BLK_W'(item_reg.block_index);

        last_blk  = hi_reg - BLK_W'(1);
        fw        = lo_reg[WAW+BIT_W-1:BIT_W];
        lw        = last_blk[WAW+BIT_W-1:BIT_W];
        lob       = (pw_reg == fw) ? lo_reg[BIT_W-1:0] : '0;
        hib       = (pw_reg == lw) ? last_blk[BIT_W-1:0] : '1;
        mask      = bpfa_pkg::span_mask(lob, hib);

        hit       = mem_rd_data != bpfa_pkg::FULL_WORD;
        zbit      = bpfa_pkg::first_zero(mem_rd_data);
        found     = {pw_reg, zbit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bpfa_pkg::S_CLEAR;
            cur_reg   <= '0;
            last_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            fix0_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            last_reg  <= last_next;
            pend_reg  <= pend_next;
            fix0_reg  <= fix0_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        status_reg <= status_next;
        pw_reg     <= pw_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        set_reg    <= set_next;
        used_reg   <= used_next;
        addr_reg   <= addr_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        status_next = status_reg;
        cur_next    = cur_reg;
        pw_next     = pw_reg;
        last_next   = last_reg;
        pend_next   = pend_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        set_next    = set_reg;
        fix0_next   = fix0_reg;
        used_next   = used_reg;
        addr_next   = addr_reg;

        req_ready   = 1'b0;
        res_valid   = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = pw_reg;
        mem_wr_data = mem_rd_data;
        mem_rd_en   = 1'b0;
        mem_rd_addr = cur_reg;

        unique case (state_reg)
            bpfa_pkg::S_CLEAR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = cur_reg;
                mem_wr_data = bpfa_pkg::FULL_WORD;
                cur_next    = cur_reg + WAW'(1);
                if (cur_reg == LAST_WORD)
                begin
                    state_next = bpfa_pkg::S_IDLE;
                end
            end

            bpfa_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    item_next   = req;
                    status_next = bpfa_pkg::ST_OK;
                    used_next   = 1'b0;
                    addr_next   = '0;
                    state_next  = bpfa_pkg::S_PREP;
                end
            end

            bpfa_pkg::S_PREP:
            begin
                last_next = 1'b0;
                pend_next = 1'b0;
                fix0_next = 1'b0;
                unique case (item_reg.action)
                    bpfa_pkg::ACT_ALLOC:
                    begin
                        cur_next   = '0;
                        state_next = bpfa_pkg::S_SCAN;
                    end
                    bpfa_pkg::ACT_FREE:
                    begin
                        if (start_blk >= NUM_B)
                        begin
                            status_next = bpfa_pkg::ST_RANGE;
                            state_next  = bpfa_pkg::S_DONE;
                        end
                        else
                        begin
                            lo_next    = start_blk;
                            hi_next    = start_blk + BLK_W'(1);
                            set_next   = 1'b0;
                            cur_next   = start_blk[WAW+BIT_W-1:BIT_W];
                            state_next = bpfa_pkg::S_SPAN;
                        end
                    end
                    bpfa_pkg::ACT_REGION_USED,
                    bpfa_pkg::ACT_REGION_UNUSED:
                    begin
                        lo_next   = start_blk;
                        hi_next   = over ? NUM_B : end_raw;
                        set_next  = item_reg.action == bpfa_pkg::ACT_REGION_USED;
                        fix0_next = item_reg.action == bpfa_pkg::ACT_REGION_UNUSED;
                        cur_next  = start_blk[WAW+BIT_W-1:BIT_W];
                        if (cnt != '0 && over)
                        begin
                            status_next = bpfa_pkg::ST_RANGE;
                        end
                        // A run with no block in the bitmap skips the span pass.
                        if (cnt == '0 || start_blk >= NUM_B)
                        begin
                            state_next = (item_reg.action == bpfa_pkg::ACT_REGION_UNUSED)
                                         ? bpfa_pkg::S_FIX0 : bpfa_pkg::S_DONE;
                        end
                        else
                        begin
                            state_next = bpfa_pkg::S_SPAN;
                        end
                    end
                    bpfa_pkg::ACT_TEST:
                    begin
                        if (idx_ext >= NUM_B)
                        begin
                            status_next = bpfa_pkg::ST_RANGE;
                            state_next  = bpfa_pkg::S_DONE;
                        end
                        else
                        begin
                            state_next = bpfa_pkg::S_TEST_RD;
                        end
                    end
                    default:
                    begin
                        state_next = bpfa_pkg::S_DONE;
                    end
                endcase
            end

            bpfa_pkg::S_SPAN:
            begin
                // Read one word per cycle and write the previous one back.
                if (!last_reg)
                begin
                    mem_rd_en = 1'b1;
                    cur_next  = cur_reg + WAW'(1);
                    last_next = cur_reg == lw;
                    pw_next   = cur_reg;
                end
                pend_next = !last_reg;
                if (pend_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_data = set_reg ? (mem_rd_data | mask) : (mem_rd_data & ~mask);
                end
                if (last_reg && !pend_reg)
                begin
                    state_next = fix0_reg ? bpfa_pkg::S_FIX0 : bpfa_pkg::S_DONE;
                end
            end

            bpfa_pkg::S_FIX0:
            begin
                lo_next    = '0;
                hi_next    = BLK_W'(1);
                set_next   = 1'b1;
                fix0_next  = 1'b0;
                cur_next   = '0;
                last_next  = 1'b0;
                pend_next  = 1'b0;
                state_next = bpfa_pkg::S_SPAN;
            end

            bpfa_pkg::S_SCAN:
            begin
                if (!last_reg)
                begin
                    mem_rd_en = 1'b1;
                    cur_next  = cur_reg + WAW'(1);
                    last_next = cur_reg == LAST_WORD;
                    pw_next   = cur_reg;
                end
                pend_next = !last_reg;
                if (pend_reg && hit)
                begin
                    state_next = bpfa_pkg::S_DONE;
                    if (found == '0)
                    begin
                        status_next = bpfa_pkg::ST_OOM;
                    end
                    else
                    begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = mem_rd_data | (32'd1 << zbit);
                        addr_next   = ADDR_W'(found) << SHIFT;
                    end
                end
                else if (pend_reg && last_reg)
                begin
                    status_next = bpfa_pkg::ST_OOM;
                    state_next  = bpfa_pkg::S_DONE;
                end
            end

            bpfa_pkg::S_TEST_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = idx_ext[WAW+BIT_W-1:BIT_W];
                state_next  = bpfa_pkg::S_TEST_DATA;
            end

            bpfa_pkg::S_TEST_DATA:
            begin
                used_next  = mem_rd_data[idx_ext[BIT_W-1:0]];
                state_next = bpfa_pkg::S_DONE;
            end

            bpfa_pkg::S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = bpfa_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = bpfa_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.alloc_address = addr_reg;
        res.block_used    = used_reg;
        res.status        = status_reg;
    end

endmodule

[rtl/bitmap_page_frame_allocator_top.sv]
// Top level of the bitmap page frame allocator: bitmap memory, sequencer and result register.
`timescale 1ns / 1ps

// The allocator keeps one bit per 4096-byte block in a single 32-bit-wide memory
// of ceil(NUM_BLOCKS/32) words; a set bit means the block is used. After reset the
// block runs a clearing pass that writes every word to all ones, one word per cycle,
// and accepts no item until it is done. Every item is then handled alone, as read
// or read-modify-write passes through the memory's single read and single write
// port. Region-unused also forces block 0 used after its run, and alloc scans the
// words up to the first word with a clear bit, so the whole bitmap in the worst
// case. Alloc reports out of memory when no block is free or when the lowest free
// block is block 0, which stays free. Free and test of blocks past the bitmap, and
// regions that reach past it, report out of range; regions still update the blocks
// that lie inside. The result register lets the next item be accepted while a
// finished result waits to be taken.

module bitmap_page_frame_allocator_top #(
    parameter int unsigned NUM_BLOCKS = 32768
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  bpfa_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output bpfa_pkg::rsp_t rsp
);

    localparam int unsigned WORD_COUNT = (NUM_BLOCKS + 31) / 32;
    localparam int unsigned WAW        = WORD_COUNT > 1 ? $clog2(WORD_COUNT) : 1;

    logic           mem_wr_en;
    logic [WAW-1:0] mem_wr_addr;
    logic [31:0]    mem_wr_data;
    logic           mem_rd_en;
    logic [WAW-1:0] mem_rd_addr;
    logic [31:0]    mem_rd_data;

    logic           res_valid;
    logic           slot_free;
    bpfa_pkg::rsp_t res;

    logic           rsp_valid_reg, rsp_valid_next;
    bpfa_pkg::rsp_t rsp_reg, rsp_next;

    bpfa_ram #(
        .WIDTH (32),
        .DEPTH (WORD_COUNT)
    ) u_bitmap (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    bpfa_ctrl #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .res_valid   (res_valid),
        .res_ready   (slot_free),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    // The result register takes a new item when it is empty or being emptied.
    assign slot_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (slot_free)
        begin
            rsp_valid_next = res_valid;
            if (res_valid)
            begin
                rsp_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // A word is never read in the same cycle in which it is written back.
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
        else $error("bitmap word read and written in the same cycle");

    // While waiting for an item the bitmap is not being modified.
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> !mem_wr_en)
        else $error("bitmap written while idle");

    // An out-of-memory result never carries an address.
    a_oom_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == bpfa_pkg::ST_OOM) |-> (rsp.alloc_address == '0))
        else $error("out-of-memory result with nonzero address");

    // A result enters the output register only in the cycle after the sequencer offers it.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(res_valid))
        else $error("result appeared without the sequencer offering one");

endmodule
